@@ sv/uart_baud_divisor_search_macros.svh @@
// assertion macros shared by the baud divisor search files
`ifndef UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
// property that must hold on every clock edge out of reset
`define UBDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked in the next cycle
`define UBDS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

@@ sv/ubds_pkg.sv @@
// constants and types for the baud divisor search
package ubds_pkg;
	localparam int CLK_W     = 32;
	localparam int BAUD_W    = 24;
	localparam int WORD_W    = 29;
	localparam int OSR_MIN   = 4;
	localparam int OSR_MAX   = 32;
	localparam int OSR_W     = 6;
	localparam int SBR_LIMIT = 8191;
	localparam int SBR_W     = 16;
	localparam int SBR_FLD_W = 13;
	localparam int OSR_SHIFT = 24;
	localparam int DEN_W     = 40;
	localparam int NUM_W     = 41;
	localparam int DCNT_W    = 6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEN, ST_DIV1, ST_CHK, ST_MUL2, ST_DIV2, ST_CMP, ST_NEXT, ST_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;
endpackage

@@ sv/ubds_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module ubds_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ubds_pkg::div_ctl_t            ctl,
	input  logic [ubds_pkg::NUM_W-1:0]    num,
	input  logic [ubds_pkg::DEN_W-1:0]    den,
	output logic                          busy,
	output logic [ubds_pkg::NUM_W-1:0]    quo
);
	import ubds_pkg::*;

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W:0]    rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [DEN_W+1:0]  trial;
	logic [DEN_W:0]    shifted;

	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

	`include "uart_baud_divisor_search_macros.svh"
	`UBDS_ASSERT_NEXT(a_start_busy, ctl.start, busy_q, "divider did not start")
	`UBDS_ASSERT(a_no_restart, !(ctl.start && busy_q), "divider restarted while busy")
	`UBDS_ASSERT(a_rem_lt_den, !busy_q || (rem_q < {1'b0, den_q}), "remainder out of range")
endmodule

@@ sv/uart_baud_divisor_search.sv @@
// uart baud divisor search: tries ratios 4..32 with a shared serial divider
// per ratio: a first division gives the divisor, then a multiply, a second division and a
// compare; a divisor out of range skips the second division, zero inputs go straight to the result; stops on zero error
// requests: one at a time, the next accepted in the cycle after the result is taken;
// a stalled result holds the block
// reset: asynchronous active low, returns to idle with no result pending
module uart_baud_divisor_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ubds_pkg::CLK_W-1:0]    clk_hz,
	input  logic [ubds_pkg::BAUD_W-1:0]   baud_rate,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ubds_pkg::WORD_W-1:0]   baud_word,
	output logic                          failed
);
	import ubds_pkg::*;

	state_t state_q, state_d;
	logic [CLK_W-1:0]  clk_q;
	logic [BAUD_W-1:0] baud_q;
	logic [OSR_W-1:0]  ratio_q;
	logic [DEN_W-1:0]  den_q;
	logic [SBR_W-1:0]  div_q;
	logic [CLK_W:0]    win_err_q;
	logic [OSR_W-1:0]  win_ratio_q;
	logic [SBR_W-1:0]  win_div_q;
	logic              found_q;
	logic [WORD_W-1:0] word_q;
	logic              fail_q;
	div_ctl_t          dctl;
	logic [NUM_W-1:0]  dnum;
	logic [DEN_W-1:0]  dden;
	logic              dbusy;
	logic [NUM_W-1:0]  dquo;
	logic [CLK_W:0]    act_ext;
	logic [CLK_W:0]    err_c;
	logic [SBR_W-1:0]  div_c;
	logic [39:0]       lhs, rhs;

	ubds_divider u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dden),
		.busy(dbusy), .quo(dquo)
	);

	assign act_ext = dquo[CLK_W:0];
	assign err_c = (act_ext >= {9'd0, baud_q}) ? act_ext - {9'd0, baud_q}
	                                          : {9'd0, baud_q} - act_ext;
	assign div_c = (dquo > NUM_W'(SBR_LIMIT)) ? SBR_W'(SBR_LIMIT + 1) : dquo[SBR_W-1:0];
	// err * 100 as 64 + 32 + 4
	assign lhs = {2'd0, win_err_q[CLK_W-1:0], 6'd0} + {3'd0, win_err_q[CLK_W-1:0], 5'd0}
	             + {6'd0, win_err_q[CLK_W-1:0], 2'd0};
	assign rhs = {15'd0, baud_q, 1'b0} + {16'd0, baud_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DEN;
			ST_DEN:  state_d = (clk_q == '0 || baud_q == '0) ? ST_FIN : ST_DIV1;
			ST_DIV1: if (!dbusy) state_d = ST_CHK;
			ST_CHK:  state_d = ST_MUL2;
			ST_MUL2: state_d = (div_q == '0 || div_q > SBR_W'(SBR_LIMIT)) ? ST_NEXT : ST_DIV2;
			ST_DIV2: if (!dbusy) state_d = ST_CMP;
			ST_CMP:  state_d = ST_NEXT;
			ST_NEXT: state_d = (ratio_q == OSR_W'(OSR_MAX) || (found_q && win_err_q == '0))
			                   ? ST_FIN : ST_DEN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dctl.start = 1'b0;
		dnum = '0;
		dden = den_q;
		unique case (state_q)
			ST_DEN: begin
				dctl.start = (clk_q != '0 && baud_q != '0);
				dnum = {9'd0, clk_q} + {2'd0, den_q[DEN_W-1:1]};
			end
			ST_MUL2: begin
				dctl.start = !(div_q == '0 || div_q > SBR_W'(SBR_LIMIT));
				dnum = {9'd0, clk_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// den is baud*ratio for the first division, formed before ST_DEN; 24x6 product stays narrow
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				clk_q <= clk_hz;
				baud_q <= baud_rate;
				ratio_q <= OSR_W'(OSR_MIN);
				den_q <= {10'd0, {6'd0, baud_rate} * 30'(OSR_MIN)};
				found_q <= 1'b0;
				win_err_q <= '0;
				win_ratio_q <= '0;
				win_div_q <= '0;
			end
			ST_CHK: begin
				// divisor times ratio, ready when the second division starts
				div_q <= div_c;
				den_q <= {18'd0, {6'd0, div_c} * {16'd0, ratio_q}};
			end
			ST_CMP: begin
				if (!found_q || err_c < win_err_q) begin
					found_q <= 1'b1;
					win_err_q <= err_c;
					win_ratio_q <= ratio_q;
					win_div_q <= div_q;
				end
			end
			ST_NEXT: begin
				ratio_q <= ratio_q + 1'b1;
				den_q <= {10'd0, {6'd0, baud_q} * {24'd0, ratio_q + 1'b1}};
			end
			ST_FIN: begin
				if (found_q && !(lhs > rhs)) begin
					word_q <= WORD_W'({win_ratio_q - 1'b1, 24'd0})
					          | WORD_W'(win_div_q[SBR_FLD_W-1:0]);
					fail_q <= 1'b0;
				end else begin
					word_q <= '0;
					fail_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign baud_word = word_q;
	assign failed    = fail_q;

	`include "uart_baud_divisor_search_macros.svh"
	`UBDS_ASSERT(a_fail_zero, !out_valid || !failed || baud_word == '0, "failed with nonzero word")
	`UBDS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(baud_word),
		"result changed while stalled")
	`UBDS_ASSERT(a_one_side, !(out_valid && !in_stall), "accepting while result pending")
endmodule

@@ verif/uart_baud_divisor_search_tb.sv @@
// testbench for the uart baud divisor search block
`timescale 1ns / 100ps

module uart_baud_divisor_search_tb;
	import ubds_pkg::*;

	localparam int LAT_MAX = 29 * 90 + 8;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CLK_W-1:0] clk_hz = '0;
	logic [BAUD_W-1:0] baud_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] baud_word;
	logic failed;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic fail;
	} setting_t;

	setting_t pending_settings[$];
	int mismatches = 0;
	int requests_sent = 0;
	int settings_seen = 0;
	int failures_seen = 0;
	longint cycles = 0;

	uart_baud_divisor_search dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.clk_hz(clk_hz), .baud_rate(baud_rate),
		.out_valid(out_valid), .out_stall(out_stall),
		.baud_word(baud_word), .failed(failed)
	);

	always #2 clk = ~clk;

	// search the ratios in order for the closest truncated rate, stopping on zero error
	function automatic setting_t search_setting(logic [CLK_W-1:0] f, logic [BAUD_W-1:0] b);
		setting_t s;
		longint unsigned den, dv, act, err, least_err, best_r, best_d;
		bit found;
		s.word = '0;
		s.fail = 1'b1;
		found = 0;
		least_err = 0;
		best_r = 0;
		best_d = 0;
		if (f != 0 && b != 0) begin
			for (int r = OSR_MIN; r <= OSR_MAX; r++) begin
				den = longint'(b) * r;
				dv = (longint'(f) + den / 2) / den;
				if (dv == 0 || dv > SBR_LIMIT)
					continue;
				act = longint'(f) / (dv * r);
				err = (act >= b) ? act - b : b - act;
				if (!found || err < least_err) begin
					found = 1;
					least_err = err;
					best_r = r;
					best_d = dv;
					if (err == 0)
						break;
				end
			end
			if (found && !(least_err * 100 > longint'(b) * 3)) begin
				s.word = WORD_W'(((best_r - 1) << OSR_SHIFT) | (best_d & 64'h1FFF));
				s.fail = 1'b0;
			end
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic send_request(logic [CLK_W-1:0] f, logic [BAUD_W-1:0] b);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		clk_hz <= f;
		baud_rate <= b;
		do
			@(posedge clk);
		while (in_stall);
		pending_settings.push_back(search_setting(f, b));
		requests_sent++;
	endtask

	// random stall on the result side, drawn per result
	initial begin
		int hold;
		forever begin
			hold = $urandom_range(0, 7);
			out_stall <= (hold != 0);
			do
				@(posedge clk);
			while (!(arst_n && out_valid));
			if (hold != 0) begin
				repeat (hold - 1) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		setting_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_settings.size() == 0) begin
				report_mismatch("unexpected result", baud_word, 0);
			end else begin
				e = pending_settings.pop_front();
				settings_seen++;
				if (failed)
					failures_seen++;
				if (baud_word !== e.word)
					report_mismatch("baud_word", baud_word, e.word);
				if (failed !== e.fail)
					report_mismatch("failed", failed, e.fail);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_zero_inputs();
		send_request('0, '0);
		send_request('0, 24'd115200);
		send_request(32'd48000000, '0);
		send_request('1, '0);
	endtask

	task automatic test_extremes();
		send_request('1, '1);
		send_request('1, 24'd1);
		send_request(32'd1, 24'd1);
		send_request(32'd1, '1);
		send_request(32'd4, 24'd1);
		send_request(32'd3, 24'd1);
		send_request(32'h8000_0000, 24'h80_0000);
	endtask

	task automatic test_common_rates();
		send_request(32'd24000000, 24'd115200);
		send_request(32'd48000000, 24'd9600);
		send_request(32'd80000000, 24'd4000000);
		send_request(32'd1843200, 24'd115200);
		send_request(32'd24000000, 24'd300);
		// divisor well over the limit at every ratio
		send_request(32'd400000000, 24'd10);
		// pairs that some ratio meets with zero error
		send_request(32'd100, 24'd3);
		send_request(32'd1000, 24'd7);
		send_request(32'd6000000, 24'd1000000);
	endtask

	task automatic test_random();
		logic [CLK_W-1:0] f;
		logic [BAUD_W-1:0] b;
		for (int i = 0; i < 270; i++) begin
			case ($urandom_range(0, 4))
				0: begin
					f = $urandom();
					b = BAUD_W'($urandom());
				end
				1: begin
					f = $urandom_range(1000, 2000);
					b = BAUD_W'($urandom_range(1, 100));
				end
				default: begin
					// clock and rate pairs from a rate times a multiplier, truncated to the clock width
					b = BAUD_W'($urandom_range(1, 4000000));
					f = CLK_W'(longint'(b) * $urandom_range(4, 32 * 8191)
						+ $urandom_range(0, 1000));
				end
			endcase
			send_request(f, b);
		end
	endtask

	initial begin
		int drain;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_inputs();
		test_extremes();
		test_common_rates();
		test_random();
		in_valid <= 1'b0;
		drain = 0;
		while (pending_settings.size() != 0 && drain < 10 * LAT_MAX) begin
			@(posedge clk);
			drain++;
		end
		repeat (LAT_MAX) @(posedge clk);
		$display("sent %0d requests, checked %0d results, %0d flagged as failed",
			requests_sent, settings_seen, failures_seen);
		if (mismatches == 0 && pending_settings.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
